// ----- rtl/mhbs_pkg.sv -----
// Shared types and constants for the mail header/body splitter.
// No dependencies.
package mhbs_pkg;

    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_CR = 8'h0D;

    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;
    localparam int HDR_MAX_W  = 16;

    typedef enum logic [2:0] {
        VERDICT_NONE   = 3'd0,
        VERDICT_LF     = 3'd1,
        VERDICT_CRLF   = 3'd2,
        VERDICT_CR     = 3'd3,
        VERDICT_BUDGET = 3'd4,
        VERDICT_END    = 3'd5
    } verdict_t;

    // Register word index (byte address / 4)
    typedef enum logic [1:0] {
        REG_MAX_HEADER_BYTES = 2'd0,
        REG_SKIP_HEADERS     = 2'd1,
        REG_SKIP_BODY        = 2'd2
    } reg_idx_t;

    // break_run codes: no break, CR after text, line break seen
    localparam logic [1:0] RUN_NONE  = 2'd0;
    localparam logic [1:0] RUN_CR    = 2'd1;
    localparam logic [1:0] RUN_BREAK = 2'd2;

endpackage

// ----- rtl/mail_header_body_splitter_core.sv -----
// Mail header/body splitter: marks header window bytes and reports how the
// window closed. Depends on mhbs_pkg.
//
// Usage:
//   Input channel s_*: one word per message byte, or a stream-end word
//   (s_stream_end = 1, byte ignored). Result channel m_*: exactly one word
//   per input word, in order, with out_byte, byte_valid, byte_held, verdict
//   and drop_held.
//   Configuration over APB at 0x0 (max_header_bytes), 0x4 (skip_headers),
//   0x8 (skip_body); pready is tied high; write only while idle.
//   The result is registered and becomes valid in the cycle after the input is accepted.
//   Throughput: 1 word per cycle while m_ready stays high. The state update is
//   one compare and increment of the held-byte counter, done in the accept
//   cycle; the result register is refilled in the same cycle it drains.
//   Reset (aresetn low, synchronous): config registers and the held-byte count clear,
//   the splitter returns to header search, the result register empties.
//   A stalled receiver (m_ready low) holds the result and drops s_ready
//   once the result register is full; nothing is lost.
//   After a stream-end word the splitter rearms for the next message.
module mail_header_body_splitter_core #(
    parameter int BUDGET_BITS = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // APB configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [mhbs_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [mhbs_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [mhbs_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                pready,
    // input words
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [7:0]                          s_data_byte,
    input  logic                                s_stream_end,
    // result words
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [7:0]                          m_out_byte,
    output logic                                m_byte_valid,
    output logic                                m_byte_held,
    output logic [2:0]                          m_verdict,
    output logic                                m_drop_held
);
    import mhbs_pkg::*;

    // configuration registers
    logic [HDR_MAX_W-1:0] max_hdr_reg;
    logic                 skip_hdr_reg;
    logic                 skip_body_reg;

    // splitter state
    logic                   in_body_reg,    in_body_next;
    logic [1:0]             break_run_reg,  break_run_next;
    logic                   pending_cr_reg, pending_cr_next;
    logic [BUDGET_BITS-1:0] held_cnt_reg,   held_cnt_next;

    // result register
    logic       m_valid_reg;
    logic [7:0] out_byte_reg,   out_byte_next;
    logic       byte_valid_reg, byte_valid_next;
    logic       byte_held_reg,  byte_held_next;
    verdict_t   verdict_reg,    verdict_next;
    logic       drop_reg,       drop_next;

    logic                   cfg_wr;
    reg_idx_t               cfg_idx;
    logic [31:0]            budget_wide;
    logic [BUDGET_BITS-1:0] budget;
    logic                   s_accept;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = reg_idx_t'(paddr[3:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_hdr_reg   <= '0;
            skip_hdr_reg  <= 1'b0;
            skip_body_reg <= 1'b0;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_MAX_HEADER_BYTES: max_hdr_reg   <= pwdata[HDR_MAX_W-1:0];
                REG_SKIP_HEADERS:     skip_hdr_reg  <= pwdata[0];
                REG_SKIP_BODY:        skip_body_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_MAX_HEADER_BYTES: prdata = {{(CFG_DATA_W-HDR_MAX_W){1'b0}}, max_hdr_reg};
            REG_SKIP_HEADERS:     prdata = {{(CFG_DATA_W-1){1'b0}}, skip_hdr_reg};
            REG_SKIP_BODY:        prdata = {{(CFG_DATA_W-1){1'b0}}, skip_body_reg};
            default:              prdata = '0;
        endcase
    end

    // budget seen at BUDGET_BITS wide (truncate or zero-extend the register)
    assign budget_wide = {{(32-HDR_MAX_W){1'b0}}, max_hdr_reg};
    assign budget      = budget_wide[BUDGET_BITS-1:0];

    assign s_ready  = !m_valid_reg || m_ready;
    assign s_accept = s_valid && s_ready;

    always_comb begin
        in_body_next    = in_body_reg;
        break_run_next  = break_run_reg;
        pending_cr_next = pending_cr_reg;
        held_cnt_next   = held_cnt_reg;
        out_byte_next   = s_data_byte;
        byte_valid_next = 1'b0;
        byte_held_next  = 1'b0;
        verdict_next    = VERDICT_NONE;
        drop_next       = 1'b0;

        if (s_stream_end) begin
            out_byte_next = 8'h00;
            if (!in_body_reg) begin
                if (pending_cr_reg) begin
                    verdict_next = VERDICT_CR;
                    drop_next    = skip_hdr_reg;
                end else begin
                    verdict_next = VERDICT_END;
                    drop_next    = skip_body_reg;
                end
            end
            // rearm for next message
            in_body_next    = 1'b0;
            break_run_next  = RUN_BREAK;
            pending_cr_next = 1'b0;
            held_cnt_next   = '0;
        end else if (in_body_reg) begin
            byte_valid_next = !skip_body_reg;
        end else if (held_cnt_reg >= budget) begin
            // budget hit (or lowered) before this byte: byte is body
            verdict_next    = VERDICT_BUDGET;
            drop_next       = skip_body_reg;
            byte_valid_next = !skip_body_reg;
            in_body_next    = 1'b1;
            pending_cr_next = 1'b0;
        end else if (pending_cr_reg) begin
            pending_cr_next = 1'b0;
            in_body_next    = 1'b1;
            drop_next       = skip_hdr_reg;
            if (s_data_byte == CH_LF) begin
                verdict_next    = VERDICT_CRLF;
                byte_held_next  = 1'b1;
                byte_valid_next = 1'b1;
                held_cnt_next   = held_cnt_reg + 1'b1;
            end else begin
                // pending CR not followed by LF: this byte opens the body
                verdict_next    = VERDICT_CR;
                byte_valid_next = !skip_body_reg;
            end
        end else begin
            byte_held_next  = 1'b1;
            byte_valid_next = 1'b1;
            held_cnt_next   = held_cnt_reg + 1'b1;
            if (s_data_byte == CH_LF) begin
                if (break_run_reg == RUN_BREAK) begin
                    verdict_next = VERDICT_LF;
                    drop_next    = skip_hdr_reg;
                    in_body_next = 1'b1;
                end
                break_run_next = RUN_BREAK;
            end else if (s_data_byte == CH_CR) begin
                if (break_run_reg != RUN_NONE) begin
                    pending_cr_next = 1'b1;
                end else begin
                    break_run_next = RUN_CR;
                end
            end else begin
                break_run_next = RUN_NONE;
            end
            // byte that fills the budget; a waiting CR is abandoned
            if (!in_body_next && held_cnt_next >= budget) begin
                verdict_next    = VERDICT_BUDGET;
                drop_next       = skip_body_reg;
                in_body_next    = 1'b1;
                pending_cr_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_body_reg    <= 1'b0;
            break_run_reg  <= RUN_BREAK;
            pending_cr_reg <= 1'b0;
            held_cnt_reg   <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (s_accept) begin
                in_body_reg    <= in_body_next;
                break_run_reg  <= break_run_next;
                pending_cr_reg <= pending_cr_next;
                held_cnt_reg   <= held_cnt_next;
                m_valid_reg    <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg    <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            out_byte_reg   <= out_byte_next;
            byte_valid_reg <= byte_valid_next;
            byte_held_reg  <= byte_held_next;
            verdict_reg    <= verdict_next;
            drop_reg       <= drop_next;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_out_byte   = out_byte_reg;
    assign m_byte_valid = byte_valid_reg;
    assign m_byte_held  = byte_held_reg;
    assign m_verdict    = verdict_reg;
    assign m_drop_held  = drop_reg;

endmodule
